// ----- design/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator: table and
// store sizes, field widths, request and status codes, scan beat and cell
// command formats.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // Table and store sizes
  localparam int MAX_BLOCKS = 64;
  localparam int MAX_WORDS  = 1024;

  localparam int BLK_IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BLK_CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int WORD_IDX_W = $clog2(MAX_WORDS);
  localparam int WORD_CNT_W = $clog2(MAX_WORDS + 1);

  // Fixed field widths
  localparam int SIZE_W   = 11;
  localparam int INDEX_W  = 10;
  localparam int DATA_W   = 32;
  localparam int HANDLE_W = 6;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_SPACE = 2'd2
  } status_t;

  // Search beat handed from cell to cell
  typedef struct packed {
    logic                 active;
    logic                 found;
    logic [SIZE_W-1:0]    want;
    logic [BLK_IDX_W-1:0] handle;
  } ffba_tok_t;

  // Broadcast update of one table entry
  typedef struct packed {
    logic                 free_en;
    logic                 app_en;
    logic [BLK_IDX_W-1:0] idx;
    logic [SIZE_W-1:0]    want;
  } ffba_cmd_t;

endpackage

// ----- design/ffba_req_if.sv -----
// ----------------------------------------------------------------------------
// ffba_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface ffba_req_if import ffba_pkg::*; ();
  logic                     valid;
  logic                     ready;
  req_type_t                req_type;
  logic [SIZE_W-1:0]        block_size;
  logic [INDEX_W-1:0]       target_index;
  logic signed [DATA_W-1:0] write_data;

  modport source (output valid, req_type, block_size, target_index, write_data,
                  input ready);
  modport sink   (input valid, req_type, block_size, target_index, write_data,
                  output ready);
endinterface

// ----- design/ffba_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ffba_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface ffba_rsp_if import ffba_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [HANDLE_W-1:0]      result_handle;
  logic signed [DATA_W-1:0] read_data;
  status_t                  status;

  modport source (output valid, result_handle, read_data, status, input ready);
  modport sink   (input valid, result_handle, read_data, status, output ready);
endinterface

// ----- design/ffba_cell.sv -----
// ----------------------------------------------------------------------------
// ffba_cell
// One block table entry. Holds the entry's length, used and free flags, and
// passes the search beat on to the next cell every cycle, claiming the
// entry on the first fit.
// ----------------------------------------------------------------------------
module ffba_cell import ffba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [BLK_IDX_W-1:0] cell_idx,
  input  ffba_cmd_t            cmd,
  input  ffba_tok_t            tok_in,
  output ffba_tok_t            tok_out
);

  logic              used;
  logic              free;
  logic [SIZE_W-1:0] length;
  logic              hit;
  logic              sel;
  ffba_tok_t         tok_next;

  // Match a pending search against this entry
  assign hit = tok_in.active && !tok_in.found && used && free &&
               (length >= tok_in.want);
  assign sel = (cmd.idx == cell_idx);

  // Mark the beat with this entry on the first fit
  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found  = 1'b1;
      tok_next.handle = cell_idx;
    end
  end

  // Hold flags, advance the search beat
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      free    <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (hit) begin
        free <= 1'b0;
      end else if (cmd.app_en && sel) begin
        used <= 1'b1;
        free <= 1'b0;
      end else if (cmd.free_en && sel) begin
        free <= 1'b1;
      end
    end
  end

  // Cut length to the request on claim or append
  always_ff @(posedge clk) begin
    if (hit) begin
      length <= tok_in.want;
    end else if (cmd.app_en && sel) begin
      length <= cmd.want;
    end
  end

endmodule

// ----- design/first_fit_block_allocator_unit.sv -----
// Allocate: the search beat walks one table cell per cycle from head_act through
//   every cell register; SCAN then records the result and FINISH loads it out.
// Free and write go from IDLE to FINISH; read passes RDWAIT (registered word store read).
// One request at a time: the next beat is taken in the cycle after
//   the result is loaded into the output register, which holds while rsp stalls.
// Reset: a clearing pass zeroes all MAX_WORDS store words first.
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit block allocator over a word store. A chain of table cells does
// the first-fit search; the controller appends blocks, frees blocks and
// serves word reads and writes.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit import ffba_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ffba_req_if.sink   req,
  ffba_rsp_if.source rsp
);

  localparam int ROOM_W  = (WORD_CNT_W > SIZE_W) ? WORD_CNT_W : SIZE_W;
  localparam int FCMP_W  = (INDEX_W > BLK_CNT_W) ? INDEX_W : BLK_CNT_W;
  localparam int WCMP_W  = (INDEX_W > WORD_CNT_W) ? INDEX_W : WORD_CNT_W;

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    SCAN,
    RDWAIT,
    FINISH
  } state_t;

  state_t                   state;
  logic [WORD_IDX_W-1:0]    clr_addr;
  logic [BLK_CNT_W-1:0]     block_count;
  logic [WORD_CNT_W-1:0]    words_used;
  logic                     head_act;
  logic [SIZE_W-1:0]        head_want;
  logic                     rd_ok;
  logic [HANDLE_W-1:0]      res_handle;
  logic signed [DATA_W-1:0] res_data;
  status_t                  res_status;
  logic                     out_valid;
  logic [HANDLE_W-1:0]      out_handle;
  logic signed [DATA_W-1:0] out_data;
  status_t                  out_status;

  logic signed [DATA_W-1:0] mem [MAX_WORDS];
  logic signed [DATA_W-1:0] mem_q;
  logic                     mem_we;
  logic [WORD_IDX_W-1:0]    mem_addr;
  logic signed [DATA_W-1:0] mem_wdata;

  ffba_tok_t                tok [MAX_BLOCKS+1];
  logic [MAX_BLOCKS-1:0]    tok_act;
  ffba_tok_t                tok_end;
  ffba_cmd_t                cmd;

  logic                     accept;
  logic                     free_ok;
  logic                     word_ok;
  logic [ROOM_W-1:0]        room;
  logic                     app_ok;

  // Handshake
  assign req.ready         = (state == IDLE);
  assign accept            = req.valid && req.ready;
  assign rsp.valid         = out_valid;
  assign rsp.result_handle = out_handle;
  assign rsp.read_data     = out_data;
  assign rsp.status        = out_status;

  // Range checks
  assign free_ok = FCMP_W'(req.target_index) < FCMP_W'(block_count);
  assign word_ok = WCMP_W'(req.target_index) < WCMP_W'(words_used);
  assign room    = ROOM_W'(MAX_WORDS) - ROOM_W'(words_used);
  assign tok_end = tok[MAX_BLOCKS];
  assign app_ok  = !tok_end.found && (block_count != BLK_CNT_W'(MAX_BLOCKS)) &&
                   (ROOM_W'(tok_end.want) <= room);

  // Drive table updates: free on request, append after a failed search
  always_comb begin
    cmd.free_en = accept && (req.req_type == REQ_FREE) && free_ok;
    cmd.app_en  = (state == SCAN) && tok_end.active && app_ok;
    cmd.idx     = cmd.free_en ? BLK_IDX_W'(req.target_index)
                              : BLK_IDX_W'(block_count);
    cmd.want    = tok_end.want;
  end

  // Feed the search beat into the chain
  always_comb begin
    tok[0]        = '0;
    tok[0].active = head_act;
    tok[0].want   = head_want;
  end

  // Launch a search beat for one cycle on an allocate request
  always_ff @(posedge clk) begin
    if (rst) begin
      head_act <= 1'b0;
    end else begin
      head_act <= accept && (req.req_type == REQ_ALLOC);
    end
  end

  // Cell chain
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    assign tok_act[i] = tok[i].active;
    ffba_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (BLK_IDX_W'(i)),
      .cmd      (cmd),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  // Word store port: clearing pass or request write
  always_comb begin
    mem_we    = (state == CLEAR) ||
                (accept && (req.req_type == REQ_WRITE) && word_ok);
    mem_addr  = (state == CLEAR) ? clr_addr : WORD_IDX_W'(req.target_index);
    mem_wdata = (state == CLEAR) ? '0 : req.write_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[WORD_IDX_W'(req.target_index)];
  end

  // Sequence requests, hold the result until the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CLEAR;
      clr_addr    <= '0;
      block_count <= '0;
      words_used  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == WORD_IDX_W'(MAX_WORDS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (accept) begin
            res_handle <= '0;
            res_data   <= '0;
            res_status <= STS_OK;
            case (req.req_type)
              REQ_ALLOC: begin
                head_want <= req.block_size;
                state     <= SCAN;
              end
              REQ_FREE: begin
                if (!free_ok) res_status <= STS_RANGE;
                state <= FINISH;
              end
              REQ_WRITE: begin
                if (!word_ok) res_status <= STS_RANGE;
                state <= FINISH;
              end
              REQ_READ: begin
                rd_ok <= word_ok;
                state <= RDWAIT;
              end
              default: state <= FINISH;
            endcase
          end
        end
        SCAN: begin
          if (tok_end.active) begin
            if (tok_end.found) begin
              res_handle <= HANDLE_W'(tok_end.handle);
            end else if (app_ok) begin
              res_handle  <= HANDLE_W'(block_count);
              block_count <= block_count + 1'b1;
              words_used  <= words_used + WORD_CNT_W'(tok_end.want);
            end else begin
              res_status <= STS_SPACE;
            end
            state <= FINISH;
          end
        end
        RDWAIT: begin
          if (rd_ok) begin
            res_data <= mem_q;
          end else begin
            res_status <= STS_RANGE;
          end
          state <= FINISH;
        end
        FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_handle <= res_handle;
            out_data   <= res_data;
            out_status <= res_status;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // At most one search beat inside the chain
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_act))
    else $error("more than one search beat in the cell chain");

  // No table update while a search beat walks the chain
  a_quiet_table: assert property (@(posedge clk) disable iff (rst)
    (|tok_act) |-> !(cmd.free_en || cmd.app_en))
    else $error("table update during a search");

  // A claimed entry lies below the block count
  a_found_handle: assert property (@(posedge clk) disable iff (rst)
    (tok_end.active && tok_end.found) |-> (BLK_CNT_W'(tok_end.handle) < block_count))
    else $error("search claimed an entry beyond the block count");

  // Counters stay within the table and the store
  a_limits: assert property (@(posedge clk) disable iff (rst)
    (block_count <= BLK_CNT_W'(MAX_BLOCKS)) && (words_used <= WORD_CNT_W'(MAX_WORDS)))
    else $error("block count or used words out of bounds");

  // An append grows the table by one entry
  a_append_step: assert property (@(posedge clk) disable iff (rst)
    cmd.app_en |=> (block_count == $past(block_count) + 1'b1))
    else $error("append did not advance the block count");

endmodule
